// ===== src/itoa_pkg.sv =====
// Shared types, constants and helper functions of the integer to ASCII formatter.
package itoa_pkg;

  localparam int WordBits      = 32;
  localparam int CharBits      = 8;
  localparam int MaxChars      = 11;
  localparam int LenBits       = $clog2(MaxChars + 1);
  localparam int IdxBits       = $clog2(MaxChars);
  localparam int DecDigits     = 10;
  localparam int BcdBits       = 4 * DecDigits;
  localparam int StepsPerStage = 8;
  localparam int DabbleStages  = WordBits / StepsPerStage;
  localparam int HexDigits     = WordBits / 4;
  localparam int OctFullDigits = WordBits / 3;

  // Conversion kinds; codes 5 to 7 are unused and produce no text.
  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEX  = 3'd2,
    KIND_OCT  = 3'd3,
    KIND_CHAR = 3'd4
  } kind_t;

  typedef logic [CharBits-1:0] char_t;

  localparam char_t CharMinus = 8'h2d;
  localparam char_t CharZero  = 8'h30;

  localparam char_t DigitTable [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Payload through the decode and BCD conversion stages.
  typedef struct packed {
    logic [2:0]          kind;
    logic                neg;
    logic [WordBits-1:0] mag;
    logic [WordBits-1:0] shft;
    logic [BcdBits-1:0]  bcd;
  } conv_t;

  // Finished text: chars[0] goes out first.
  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic [LenBits-1:0]   len;
  } text_t;

  function automatic char_t digit_char(input logic [3:0] d);
    return DigitTable[d];
  endfunction

  // One shift-and-add-3 step of binary to BCD conversion.
  function automatic logic [BcdBits-1:0] dabble_step(input logic [BcdBits-1:0] bcd,
                                                     input logic b);
    logic [BcdBits-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DecDigits; i++) begin
      if (adj[4*i +: 4] >= 4'd5) adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
    end
    return {adj[BcdBits-2:0], b};
  endfunction

endpackage

// ===== src/integer_to_ascii_formatter_top.sv =====
// Top level of the integer to ASCII formatter pipeline.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  argument | arg_valid / arg_ready | req_type[2:0], value[31:0]
//  text     | chr_valid / chr_ready | char_out[7:0], last
//
// Each request passes decode, four BCD stages of eight bits, format and the
// output register before its first character goes out.
// A request of kinds 0 to 4 then sends 1 to 11 characters; the serializer and
// chr_ready set the rate. Kinds 5 to 7 produce no characters.
// Reset (rst, synchronous) empties every stage; no clearing pass is needed.
// A stall on the text channel backs up the stages; nothing is lost or repeated.
module integer_to_ascii_formatter_top import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                arg_valid,
  output logic                arg_ready,
  input  logic [2:0]          req_type,
  input  logic [WordBits-1:0] value,
  output logic                chr_valid,
  input  logic                chr_ready,
  output logic [CharBits-1:0] char_out,
  output logic                last
);

  logic  stg_valid [DabbleStages+1];
  logic  stg_ready [DabbleStages+1];
  conv_t stg_data  [DabbleStages+1];
  logic  fmt_valid;
  logic  fmt_ready;
  text_t fmt_data;

  itoa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (arg_valid),
    .in_ready  (arg_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  // BCD conversion chain
  for (genvar s = 0; s < DabbleStages; s++) begin : g_dabble
    itoa_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[s]),
      .in_ready  (stg_ready[s]),
      .in_data   (stg_data[s]),
      .out_valid (stg_valid[s+1]),
      .out_ready (stg_ready[s+1]),
      .out_data  (stg_data[s+1])
    );
  end

  itoa_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[DabbleStages]),
    .in_ready  (stg_ready[DabbleStages]),
    .in_data   (stg_data[DabbleStages]),
    .out_valid (fmt_valid),
    .out_ready (fmt_ready),
    .out_data  (fmt_data)
  );

  itoa_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fmt_valid),
    .in_ready  (fmt_ready),
    .in_data   (fmt_data),
    .out_valid (chr_valid),
    .out_ready (chr_ready),
    .char_out  (char_out),
    .last      (last)
  );

endmodule

// ===== src/itoa_front.sv =====
// Decode stage: selects the sign and magnitude of the argument word.
module itoa_front import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          req_type,
  input  logic [WordBits-1:0] value,
  output logic                out_valid,
  input  logic                out_ready,
  output conv_t               out_data
);

  logic  vld;
  conv_t data_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // negative only in signed decimal; the most negative word negates to itself
  always_comb begin
    data_next.kind = req_type;
    data_next.neg  = (req_type == KIND_SDEC) && value[WordBits-1];
    data_next.mag  = data_next.neg ? (~value + {{(WordBits-1){1'b0}}, 1'b1}) : value;
    data_next.shft = data_next.mag;
    data_next.bcd  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= data_next;
  end

endmodule

// ===== src/itoa_dabble.sv =====
// BCD conversion stage: shifts a group of magnitude bits into the BCD word.
module itoa_dabble import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  conv_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output conv_t out_data
);

  logic  vld;
  conv_t data_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // consume the top bits of the shift copy, one per step
  always_comb begin
    data_next = in_data;
    for (int k = 0; k < StepsPerStage; k++) begin
      data_next.bcd  = dabble_step(data_next.bcd, data_next.shft[WordBits-1]);
      data_next.shft = {data_next.shft[WordBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= data_next;
  end

endmodule

// ===== src/itoa_format.sv =====
// Format stage: picks digits for the kind, drops leading zeros, adds the sign.
module itoa_format import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  conv_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output text_t out_data
);

  logic               vld;
  text_t              data_next;
  logic [3:0]         dig  [MaxChars];
  char_t              full [MaxChars];
  logic [LenBits-1:0] nd;
  logic [LenBits-1:0] sh;
  logic [LenBits:0]   pos;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // digit values, index 0 least significant
  always_comb begin
    for (int j = 0; j < MaxChars; j++) dig[j] = 4'd0;
    case (in_data.kind)
      KIND_HEX: begin
        for (int j = 0; j < HexDigits; j++) dig[j] = in_data.mag[4*j +: 4];
      end
      KIND_OCT: begin
        for (int j = 0; j < OctFullDigits; j++) dig[j] = {1'b0, in_data.mag[3*j +: 3]};
        dig[MaxChars-1] = {2'b00, in_data.mag[WordBits-1:WordBits-2]};
      end
      default: begin
        for (int j = 0; j < DecDigits; j++) dig[j] = in_data.bcd[4*j +: 4];
      end
    endcase
  end

  // significant digit count (zero still shows one digit), then left-align
  always_comb begin
    nd = LenBits'(1);
    for (int j = 1; j < MaxChars; j++) begin
      if (dig[j] != 4'd0) nd = LenBits'(j + 1);
    end
    for (int k = 0; k < MaxChars; k++) full[k] = digit_char(dig[MaxChars-1-k]);
    // a negative value has at most ten digits, so one slot is always free for '-'
    sh = LenBits'(MaxChars) - nd - {{(LenBits-1){1'b0}}, in_data.neg};

    data_next = '0;
    for (int k = 0; k < MaxChars; k++) begin
      pos = (LenBits+1)'(k) + {1'b0, sh};
      if (pos < (LenBits+1)'(MaxChars)) data_next.chars[k] = full[pos[IdxBits-1:0]];
      else data_next.chars[k] = CharZero;
    end

    case (in_data.kind)
      KIND_SDEC, KIND_UDEC, KIND_HEX, KIND_OCT: begin
        if (in_data.neg) data_next.chars[0] = CharMinus;
        data_next.len = nd + {{(LenBits-1){1'b0}}, in_data.neg};
      end
      KIND_CHAR: begin
        data_next.chars[0] = in_data.mag[CharBits-1:0];
        data_next.len      = LenBits'(1);
      end
      default: begin
        data_next.len = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= data_next;
  end

endmodule

// ===== src/itoa_serial.sv =====
// Output serializer: sends the text of one request one character per cycle while out_ready is high.
module itoa_serial import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  text_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output char_t char_out,
  output logic  last
);

  char_t [MaxChars-1:0] chars;
  logic [LenBits-1:0]   cnt;
  logic                 fire;

  assign out_valid = (cnt != '0);
  assign fire      = out_valid && out_ready;
  assign char_out  = chars[0];
  assign last      = (cnt == LenBits'(1));
  // take the next text while the final character of this one leaves
  assign in_ready  = (cnt == '0) || (last && out_ready);

  // remaining character count; an empty text loads as zero and vanishes
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_valid && in_ready) begin
      cnt <= in_data.len;
    end else if (fire) begin
      cnt <= cnt - LenBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chars <= in_data.chars;
    end else if (fire) begin
      chars <= {CharZero, chars[MaxChars-1:1]};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LenBits'(MaxChars))
    else $error("character count out of range");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (fire && !last) |=> out_valid)
    else $error("gap inside a conversion");

  a_load_len: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (cnt == $past(in_data.len)))
    else $error("count does not match loaded text length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> !in_ready)
    else $error("text loaded over unsent characters");

endmodule
